@@ src/cheb_pkg.sv @@
// Shared constants for the Chebyshev basis evaluator: field layout and register indexes.
package cheb_pkg;

  localparam int ARG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int DEG_W = 6;
  localparam int VAL_W = 32;
  localparam int DER_W = 48;
  localparam int TRA_W = 18;

  localparam int DEG_LSB   = 0;
  localparam int VAL_LSB   = DEG_LSB + DEG_W;
  localparam int DER_LSB   = VAL_LSB + VAL_W;
  localparam int TRA_LSB   = DER_LSB + DER_W;
  localparam int M_TDATA_W = TRA_LSB + TRA_W;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 2'd2;

endpackage

@@ src/chebyshev_basis_eval_core.sv @@
// Chebyshev first-kind basis evaluator: shared-multiplier sequencer, T_n and scaled T'_n.
// Steps per input: map, clamp, then per degree the derivative and recurrence products and an emit;
// one result per degree 0..order (order clamped to MAX_ORDER); a new input is taken only when idle.
// The single 32x32 multiplier is the bottleneck: up to 5 products per degree, 48-bit operands split.
// A stalled output register holds the sequencer at the emit step only.
// Reset: asynchronous active low; center=0, scale=1.0, order=8, idle, no pending output.
module chebyshev_basis_eval_core #(
  parameter int MAX_ORDER = 63,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cheb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cheb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [cheb_pkg::ARG_W-1:0]       s_axis_tdata,   // [31:0] arg
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [5:0] degree, [37:6] poly_value, [85:38] poly_deriv, [103:86] translated_arg
  output logic [cheb_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tuser,   // [0] in_range
  output logic                             m_axis_tlast
);

  localparam int TW = FRAC_BITS + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAP   = 4'd1;
  localparam logic [3:0] S_CLAMP = 4'd2;
  localparam logic [3:0] S_DLO   = 4'd3;
  localparam logic [3:0] S_DHI   = 4'd4;
  localparam logic [3:0] S_DACC  = 4'd5;
  localparam logic [3:0] S_TLO   = 4'd6;
  localparam logic [3:0] S_THI   = 4'd7;
  localparam logic [3:0] S_TACC  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  localparam logic [63:0]        ONE_64 = 64'd1 << FRAC_BITS;
  localparam logic [TW-1:0]      ONE_T  = TW'(ONE_64);
  localparam logic [31:0]        ONE_V  = 32'(ONE_64);
  localparam logic [47:0]        ONE_D  = 48'(ONE_64);
  localparam logic [79:0]        MAG47  = 80'd1 << 47;
  localparam logic signed [34:0] T_MAX  = 35'sd2147483647;
  localparam logic signed [34:0] T_MIN  = -35'sd2147483648;
  localparam logic signed [50:0] D_MAX  = 51'sd140737488355327;
  localparam logic signed [50:0] D_MIN  = -51'sd140737488355328;
  localparam logic [5:0]         ORD_LIM = 6'(MAX_ORDER);

  logic [3:0]  state_q, state_d;
  logic signed [31:0] center_q;
  logic [30:0] scale_q;
  logic [5:0]  order_q;
  logic [5:0]  ord_q, n_q;

  logic signed [32:0]    d_q;
  logic signed [TW-1:0]  t_q;
  logic                  inside_q;
  logic signed [31:0]    tp_q, tc_q, tn_q;
  logic signed [47:0]    dp_q, dc_q, dn_q, der_q;
  logic signed [32:0]    qtt_q;
  logic [63:0]           prod_q, acc_q;

  logic                  m_valid_q;
  logic [5:0]            o_deg_q;
  logic [31:0]           o_val_q;
  logic [47:0]           o_der_q;
  logic [17:0]           o_tra_q;
  logic                  o_inr_q, o_last_q;

  logic [31:0] d_mag, tc_mag, t_mag32, mul_a, mul_b;
  logic [32:0] d_abs;
  logic [TW-1:0] t_mag;
  logic [47:0] dc_mag;
  logic [63:0] mul_p, prod_sh;
  logic [79:0] wide_sum, wide_sh;
  logic signed [TW-1:0] t_new;
  logic        inside_new;
  logic [47:0] der_w;
  logic        qtd_neg, qtt_neg;
  logic signed [48:0] qtd_w;
  logic signed [32:0] qtt_w;
  logic signed [34:0] tn_sum;
  logic signed [50:0] dn_sum;
  logic signed [31:0] tn_sat;
  logic signed [47:0] dn_sat;
  logic signed [63:0] t_ext;
  logic        in_acc, out_free;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // operand magnitudes
  assign d_abs   = d_q[32] ? 33'(~d_q + 1'b1) : 33'(d_q);
  assign d_mag   = d_abs[31:0];
  assign t_mag   = t_q[TW-1] ? TW'(~t_q + 1'b1) : TW'(t_q);
  assign t_mag32 = 32'(t_mag);
  assign tc_mag  = tc_q[31] ? 32'(~tc_q + 1'b1) : 32'(tc_q);
  assign dc_mag  = dc_q[47] ? 48'(~dc_q + 1'b1) : 48'(dc_q);

  always_comb begin
    case (state_q)
      S_MAP: begin
        mul_a = d_mag;
        mul_b = {1'b0, scale_q};
      end
      S_DLO: begin
        mul_a = {1'b0, scale_q};
        mul_b = dc_mag[31:0];
      end
      S_DHI: begin
        mul_a = {1'b0, scale_q};
        mul_b = {16'd0, dc_mag[47:32]};
      end
      S_DACC: begin
        mul_a = t_mag32;
        mul_b = tc_mag;
      end
      S_TLO: begin
        mul_a = t_mag32;
        mul_b = dc_mag[31:0];
      end
      S_THI: begin
        mul_a = t_mag32;
        mul_b = {16'd0, dc_mag[47:32]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_sh  = prod_q >> FRAC_BITS;
  assign wide_sum = {16'd0, acc_q} + {prod_q[47:0], 32'd0};
  assign wide_sh  = wide_sum >> FRAC_BITS;

  // translation and clamp
  always_comb begin
    if (prod_sh > ONE_64) begin
      inside_new = 1'b0;
      t_new      = d_q[32] ? TW'(~ONE_T + 1'b1) : ONE_T;
    end else begin
      inside_new = 1'b1;
      t_new      = d_q[32] ? TW'(~prod_sh + 1'b1) : TW'(prod_sh);
    end
  end

  // scale * T'_n, saturated to 48 bits
  always_comb begin
    if (!inside_q) begin
      der_w = '0;
    end else if (dc_q[47]) begin
      der_w = (wide_sh > MAG47) ? 48'h8000_0000_0000 : 48'(~wide_sh[47:0] + 48'd1);
    end else begin
      der_w = (wide_sh >= MAG47) ? 48'h7FFF_FFFF_FFFF : wide_sh[47:0];
    end
  end

  assign qtt_neg = t_q[TW-1] ^ tc_q[31];
  assign qtt_w   = qtt_neg ? -$signed({1'b0, prod_sh[31:0]}) : $signed({1'b0, prod_sh[31:0]});
  assign qtd_neg = t_q[TW-1] ^ dc_q[47];
  assign qtd_w   = qtd_neg ? -$signed({1'b0, wide_sh[47:0]}) : $signed({1'b0, wide_sh[47:0]});

  assign tn_sum = (35'(qtt_q) <<< 1) - 35'(tp_q);
  assign dn_sum = (51'(tc_q) <<< 1) + (51'(qtd_w) <<< 1) - 51'(dp_q);
  assign tn_sat = (tn_sum > T_MAX) ? 32'sh7FFF_FFFF :
                  (tn_sum < T_MIN) ? 32'sh8000_0000 : 32'(tn_sum);
  assign dn_sat = (dn_sum > D_MAX) ? 48'sh7FFF_FFFF_FFFF :
                  (dn_sum < D_MIN) ? 48'sh8000_0000_0000 : 48'(dn_sum);

  assign t_ext = 64'(t_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_MAP;
      S_MAP:   state_d = S_CLAMP;
      S_CLAMP: state_d = S_DLO;
      S_DLO:   state_d = S_DHI;
      S_DHI:   state_d = S_DACC;
      S_DACC:  state_d = (n_q == 6'd0) ? S_EMIT : S_TLO;
      S_TLO:   state_d = S_THI;
      S_THI:   state_d = S_TACC;
      S_TACC:  state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) state_d = (n_q == ord_q) ? S_IDLE : S_DLO;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      center_q  <= '0;
      scale_q   <= 31'd65536;
      order_q   <= 6'd8;
      ord_q     <= '0;
      n_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cheb_pkg::REG_CENTER: center_q <= $signed(cfg_data_i[31:0]);
          cheb_pkg::REG_SCALE:  scale_q  <= cfg_data_i[30:0];
          cheb_pkg::REG_ORDER:  order_q  <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (in_acc) ord_q <= (order_q > ORD_LIM) ? ORD_LIM : order_q;
      if (state_q == S_CLAMP) n_q <= '0;
      if (state_q == S_EMIT && out_free) begin
        m_valid_q <= 1'b1;
        n_q       <= n_q + 6'd1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      S_IDLE: begin
        if (in_acc) d_q <= 33'($signed(s_axis_tdata)) - 33'(center_q);
      end
      S_CLAMP: begin
        t_q      <= t_new;
        inside_q <= inside_new;
        tc_q     <= $signed(ONE_V);
        tp_q     <= '0;
        dc_q     <= '0;
        dp_q     <= '0;
      end
      S_DHI: acc_q <= prod_q;
      S_DACC: begin
        der_q <= $signed(der_w);
        tn_q  <= 32'(t_q);
        dn_q  <= $signed(ONE_D);
      end
      S_TLO: qtt_q <= qtt_w;
      S_THI: acc_q <= prod_q;
      S_TACC: begin
        tn_q <= tn_sat;
        dn_q <= dn_sat;
      end
      S_EMIT: begin
        if (out_free) begin
          o_deg_q  <= n_q;
          o_val_q  <= tc_q;
          o_der_q  <= der_q;
          o_tra_q  <= t_ext[17:0];
          o_inr_q  <= inside_q;
          o_last_q <= (n_q == ord_q);
          tp_q     <= tc_q;
          tc_q     <= tn_q;
          dp_q     <= dc_q;
          dc_q     <= dn_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {o_tra_q, o_der_q, o_val_q, o_deg_q};
  assign m_axis_tuser  = o_inr_q;
  assign m_axis_tlast  = o_last_q;

endmodule

@@ src/cheb_checker.sv @@
// Port-level checks for the Chebyshev basis evaluator, bound to the top level.
module cheb_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [cheb_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);

  localparam logic [cheb_pkg::VAL_W-1:0] ONE_V = 32'd1 << FRAC_BITS;

  logic [cheb_pkg::DEG_W-1:0] deg;
  logic [cheb_pkg::VAL_W-1:0] val;
  logic [cheb_pkg::DER_W-1:0] der;

  assign deg = m_axis_tdata[cheb_pkg::DEG_LSB +: cheb_pkg::DEG_W];
  assign val = m_axis_tdata[cheb_pkg::VAL_LSB +: cheb_pkg::VAL_W];
  assign der = m_axis_tdata[cheb_pkg::DER_LSB +: cheb_pkg::DER_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_deg0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && deg == '0 |-> val == ONE_V && der == '0)
    else $error("degree zero result is not one with zero slope");

  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> der == '0)
    else $error("nonzero derivative for clamped argument");

endmodule

bind chebyshev_basis_eval_core cheb_checker #(.FRAC_BITS(FRAC_BITS)) u_cheb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
